[rtl/core/ser_pkg.sv]
// shared types, codes and constants for the sprite erase/redraw scheduler
// used by ser_table, ser_ctrl, sprite_erase_redraw_scheduler and the testbench; no dependencies
package ser_pkg;

   // table and field constants
   localparam int          SPRITE_COUNT_DEFAULT = 16;
   localparam logic [7:0]  HIDDEN_PATTERN       = 8'hff;
   localparam logic [7:0]  Y_OFFSET_RESET       = 8'd0;
   localparam logic [7:0]  MAX_Y_RESET          = 8'd176;

   // register file
   localparam int          CSR_ADDR_W = 3;
   localparam int          CSR_DATA_W = 32;
   localparam logic        CSR_REG_Y_OFFSET = 1'b0;
   localparam logic        CSR_REG_MAX_Y    = 1'b1;

   // request commands
   typedef enum logic [1:0] {
      CMD_SHOW     = 2'd0,
      CMD_HIDE     = 2'd1,
      CMD_HIDE_ALL = 2'd2,
      CMD_UPDATE   = 2'd3
   } cmd_type;

   // response operations
   typedef enum logic [1:0] {
      OP_ERASE = 2'd0,
      OP_DRAW  = 2'd1,
      OP_SWAP  = 2'd2
   } rsp_op_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ERASE,
      ST_AGE,
      ST_DRAW,
      ST_SWAP
   } state_type;

   // table operations
   typedef enum logic [2:0] {
      TBL_NONE,
      TBL_SHOW,
      TBL_HIDE,
      TBL_HIDE_ALL,
      TBL_AGE,
      TBL_COPY
   } tbl_op_type;

   typedef struct packed {
      logic [7:0] x;
      logic [7:0] y;
   } pos_type;

   typedef struct packed {
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] pattern;
   } slot_type;

   // command from the sequencer to the sprite table
   typedef struct packed {
      tbl_op_type op;
      slot_type   slot;
   } tbl_cmd_type;

endpackage

[rtl/core/ser_table.sv]
// sprite table: current, previous and oldest slot per sprite
// depends on ser_pkg
module ser_table #(
   parameter int  SPRITE_COUNT = ser_pkg::SPRITE_COUNT_DEFAULT,
   localparam int IDX_W        = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ser_pkg::tbl_cmd_type  tbl_cmd,
   input  logic [IDX_W-1:0]      tbl_addr,
   output ser_pkg::slot_type     cur_rd,
   output ser_pkg::slot_type     prev_rd,
   output ser_pkg::slot_type     old_rd
);
   import ser_pkg::*;

   logic [7:0] cur_pat_ff  [SPRITE_COUNT];
   logic [7:0] prev_pat_ff [SPRITE_COUNT];
   logic [7:0] old_pat_ff  [SPRITE_COUNT];
   pos_type    cur_pos_ff  [SPRITE_COUNT];
   pos_type    prev_pos_ff [SPRITE_COUNT];
   pos_type    old_pos_ff  [SPRITE_COUNT];

   // patterns: reset to hidden, hide all clears every slot at once
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SPRITE_COUNT; i++) begin
            cur_pat_ff[i]  <= HIDDEN_PATTERN;
            prev_pat_ff[i] <= HIDDEN_PATTERN;
            old_pat_ff[i]  <= HIDDEN_PATTERN;
         end
      end else begin
         case (tbl_cmd.op)
            TBL_SHOW: cur_pat_ff[tbl_addr] <= tbl_cmd.slot.pattern;
            TBL_HIDE: cur_pat_ff[tbl_addr] <= HIDDEN_PATTERN;
            TBL_HIDE_ALL: begin
               for (int i = 0; i < SPRITE_COUNT; i++) begin
                  cur_pat_ff[i]  <= HIDDEN_PATTERN;
                  prev_pat_ff[i] <= HIDDEN_PATTERN;
                  old_pat_ff[i]  <= HIDDEN_PATTERN;
               end
            end
            TBL_AGE:  old_pat_ff[tbl_addr]  <= prev_pat_ff[tbl_addr];
            TBL_COPY: prev_pat_ff[tbl_addr] <= cur_pat_ff[tbl_addr];
            default: ;
         endcase
      end
   end

   // positions: only meaningful while the pattern is visible
   always_ff @(posedge clock) begin
      case (tbl_cmd.op)
         TBL_SHOW: cur_pos_ff[tbl_addr] <= '{x: tbl_cmd.slot.x, y: tbl_cmd.slot.y};
         TBL_AGE:  old_pos_ff[tbl_addr]  <= prev_pos_ff[tbl_addr];
         TBL_COPY: prev_pos_ff[tbl_addr] <= cur_pos_ff[tbl_addr];
         default: ;
      endcase
   end

   // read port at the sequencer address
   always_comb begin
      cur_rd  = '{x: cur_pos_ff[tbl_addr].x, y: cur_pos_ff[tbl_addr].y,
                  pattern: cur_pat_ff[tbl_addr]};
      prev_rd = '{x: prev_pos_ff[tbl_addr].x, y: prev_pos_ff[tbl_addr].y,
                  pattern: prev_pat_ff[tbl_addr]};
      old_rd  = '{x: old_pos_ff[tbl_addr].x, y: old_pos_ff[tbl_addr].y,
                  pattern: old_pat_ff[tbl_addr]};
   end

endmodule

[rtl/core/ser_ctrl.sv]
// sequencer with one shared on-screen compare unit and the response register
// depends on ser_pkg; drives ser_table
module ser_ctrl #(
   parameter int  SPRITE_COUNT = ser_pkg::SPRITE_COUNT_DEFAULT,
   localparam int IDX_W        = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_cmd,
   input  logic [3:0]            req_index,
   input  logic [7:0]            req_x,
   input  logic [7:0]            req_y,
   input  logic [7:0]            req_pattern,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_op,
   output logic [7:0]            rsp_out_x,
   output logic [7:0]            rsp_out_y,
   output logic [7:0]            rsp_out_pattern,
   output logic                  rsp_last,
   // settings
   input  logic [7:0]            y_offset,
   input  logic [7:0]            max_y,
   // sprite table
   output ser_pkg::tbl_cmd_type  tbl_cmd,
   output logic [IDX_W-1:0]      tbl_addr,
   input  ser_pkg::slot_type     cur_rd,
   input  ser_pkg::slot_type     prev_rd,
   input  ser_pkg::slot_type     old_rd
);
   import ser_pkg::*;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_op_ff, rsp_op_in;
   slot_type         rsp_slot_ff, rsp_slot_in;
   logic             rsp_last_ff, rsp_last_in;

   slot_type         chk_slot;
   logic             chk_vis;
   logic             cnt_last;
   logic             rsp_free;
   logic             req_fire;
   logic             in_range;
   cmd_type          cmd;
   logic             emit;
   rsp_op_type       emit_op;
   slot_type         emit_slot;
   logic             emit_last;

   assign cmd       = cmd_type'(req_cmd);
   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && (state_ff == ST_IDLE);
   assign in_range  = (int'(req_index) < SPRITE_COUNT);
   assign cnt_last  = (cnt_ff == IDX_W'(SPRITE_COUNT - 1));
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign tbl_addr  = (state_ff == ST_IDLE) ? IDX_W'(req_index) : cnt_ff;

   // shared on-screen compare unit
   always_comb begin
      unique case (state_ff)
         ST_ERASE: chk_slot = old_rd;
         ST_AGE:   chk_slot = prev_rd;
         default:  chk_slot = cur_rd;
      endcase
      chk_vis = (chk_slot.pattern != HIDDEN_PATTERN) && (chk_slot.y <= max_y);
   end

   // next state and sprite counter
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && cmd == CMD_UPDATE) begin
               state_in = ST_ERASE;
               cnt_in   = '0;
            end
         end
         ST_ERASE: begin
            if (!chk_vis || rsp_free) state_in = ST_AGE;
         end
         ST_AGE: begin
            if (cnt_last) begin
               state_in = ST_DRAW;
               cnt_in   = '0;
            end else begin
               state_in = ST_ERASE;
               cnt_in   = cnt_ff + IDX_W'(1);
            end
         end
         ST_DRAW: begin
            if (!chk_vis || rsp_free) begin
               if (cnt_last) state_in = ST_SWAP;
               else cnt_in = cnt_ff + IDX_W'(1);
            end
         end
         ST_SWAP: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // table commands and response emission
   always_comb begin
      tbl_cmd.op   = TBL_NONE;
      tbl_cmd.slot = '{x: req_x, y: req_y + y_offset, pattern: req_pattern};
      emit         = 1'b0;
      emit_op      = OP_ERASE;
      emit_slot    = chk_slot;
      emit_last    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (cmd)
                  CMD_SHOW:     if (in_range) tbl_cmd.op = TBL_SHOW;
                  CMD_HIDE:     if (in_range) tbl_cmd.op = TBL_HIDE;
                  CMD_HIDE_ALL: tbl_cmd.op = TBL_HIDE_ALL;
                  default:      tbl_cmd.op = TBL_NONE;
               endcase
            end
         end
         ST_ERASE: begin
            emit    = chk_vis && rsp_free;
            emit_op = OP_ERASE;
         end
         ST_AGE: begin
            if (chk_vis) tbl_cmd.op = TBL_AGE;
         end
         ST_DRAW: begin
            if (!chk_vis || rsp_free) tbl_cmd.op = TBL_COPY;
            emit    = chk_vis && rsp_free;
            emit_op = OP_DRAW;
         end
         ST_SWAP: begin
            emit      = rsp_free;
            emit_op   = OP_SWAP;
            emit_slot = '0;
            emit_last = 1'b1;
         end
         default: ;
      endcase
   end

   // response register, loaded when the previous transfer has gone
   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   assign rsp_op_in    = emit ? emit_op   : rsp_op_ff;
   assign rsp_slot_in  = emit ? emit_slot : rsp_slot_ff;
   assign rsp_last_in  = emit ? emit_last : rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_op_ff   <= rsp_op_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_op          = rsp_op_ff;
   assign rsp_out_x       = rsp_slot_ff.x;
   assign rsp_out_y       = rsp_slot_ff.y;
   assign rsp_out_pattern = rsp_slot_ff.pattern;
   assign rsp_last        = rsp_last_ff;

endmodule

[rtl/core/sprite_erase_redraw_scheduler.sv]
// top level of the sprite erase/redraw scheduler: register file, sequencer, table
// depends on ser_pkg, ser_table and ser_ctrl
//
//   channel   direction   handshake             payload
//   req       in          req_valid/req_stall   cmd, index, x, y, pattern
//   rsp       out         rsp_valid/rsp_stall   op, out_x, out_y, out_pattern, last
//   csr       in/out      psel/penable/pready   paddr, pwdata, prdata (y_offset, max_y)
//
// show, hide one and hide all write the table at the transfer
// update runs as a sequence of steps, and a step with a result to send waits while the response side stalls:
//   two compare steps per sprite for erase and ageing, one per sprite for draw, then swap
// the steps run one after another on the single on-screen compare unit, used once a cycle
// synchronous reset hides every slot and loads y_offset 0 and max_y 176
module sprite_erase_redraw_scheduler #(
   parameter int SPRITE_COUNT = ser_pkg::SPRITE_COUNT_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_cmd,
   input  logic [3:0]                       req_index,
   input  logic [7:0]                       req_x,
   input  logic [7:0]                       req_y,
   input  logic [7:0]                       req_pattern,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_op,
   output logic [7:0]                       rsp_out_x,
   output logic [7:0]                       rsp_out_y,
   output logic [7:0]                       rsp_out_pattern,
   output logic                             rsp_last,
   // register port
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [ser_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [ser_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [ser_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import ser_pkg::*;

   localparam int IDX_W = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;

   logic [7:0]       y_offset_ff, y_offset_in;
   logic [7:0]       max_y_ff, max_y_in;
   logic             csr_wr;
   logic             csr_sel;
   tbl_cmd_type      tbl_cmd;
   logic [IDX_W-1:0] tbl_addr;
   slot_type         cur_rd;
   slot_type         prev_rd;
   slot_type         old_rd;

   // register file
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_sel = paddr[2];

   always_comb begin
      y_offset_in = y_offset_ff;
      max_y_in    = max_y_ff;
      if (csr_wr) begin
         unique case (csr_sel)
            CSR_REG_Y_OFFSET: y_offset_in = pwdata[7:0];
            CSR_REG_MAX_Y:    max_y_in    = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         CSR_REG_Y_OFFSET: prdata = {{(CSR_DATA_W-8){1'b0}}, y_offset_ff};
         CSR_REG_MAX_Y:    prdata = {{(CSR_DATA_W-8){1'b0}}, max_y_ff};
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         y_offset_ff <= Y_OFFSET_RESET;
         max_y_ff    <= MAX_Y_RESET;
      end else begin
         y_offset_ff <= y_offset_in;
         max_y_ff    <= max_y_in;
      end
   end

   // sequencer
   ser_ctrl #(
      .SPRITE_COUNT (SPRITE_COUNT)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_index       (req_index),
      .req_x           (req_x),
      .req_y           (req_y),
      .req_pattern     (req_pattern),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_op          (rsp_op),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_pattern (rsp_out_pattern),
      .rsp_last        (rsp_last),
      .y_offset        (y_offset_ff),
      .max_y           (max_y_ff),
      .tbl_cmd         (tbl_cmd),
      .tbl_addr        (tbl_addr),
      .cur_rd          (cur_rd),
      .prev_rd         (prev_rd),
      .old_rd          (old_rd)
   );

   // sprite table
   ser_table #(
      .SPRITE_COUNT (SPRITE_COUNT)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .tbl_cmd  (tbl_cmd),
      .tbl_addr (tbl_addr),
      .cur_rd   (cur_rd),
      .prev_rd  (prev_rd),
      .old_rd   (old_rd)
   );

endmodule

[tb/ser_checker.sv]
// stream checker for the sprite erase/redraw scheduler: watches request, response and
// register transfers, predicts the erase/draw/swap stream and compares it field by field
// depends on ser_pkg
module ser_checker #(
   parameter int SPRITES = ser_pkg::SPRITE_COUNT_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [1:0]                     req_cmd,
   input  logic [3:0]                     req_index,
   input  logic [7:0]                     req_x,
   input  logic [7:0]                     req_y,
   input  logic [7:0]                     req_pattern,
   // response channel
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [1:0]                     rsp_op,
   input  logic [7:0]                     rsp_out_x,
   input  logic [7:0]                     rsp_out_y,
   input  logic [7:0]                     rsp_out_pattern,
   input  logic                           rsp_last,
   // register port
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [ser_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [ser_pkg::CSR_DATA_W-1:0] pwdata,
   input  logic                           pready,
   // status to the testbench top
   output int                             fail_count,
   output int                             pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import ser_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] Y_OFFSET_ADDR = CSR_ADDR_W'(4 * CSR_REG_Y_OFFSET);
   localparam logic [CSR_ADDR_W-1:0] MAX_Y_ADDR    = CSR_ADDR_W'(4 * CSR_REG_MAX_Y);

   typedef struct packed {
      rsp_op_type op;
      slot_type   slot;
      logic       last;
   } frame_op_type;

   // shadow sprite table and registers
   slot_type     cur_slot [SPRITES];
   slot_type     prev_slot[SPRITES];
   slot_type     old_slot [SPRITES];
   logic [7:0]   y_offset_reg;
   logic [7:0]   max_y_reg;

   // erase/draw/swap results still owed by the block, oldest first
   frame_op_type frame_ops_q[$];

   function automatic logic on_screen(input slot_type s);
      return s.pattern != HIDDEN_PATTERN && s.y <= max_y_reg;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      fail_count++;
   endtask

   task automatic hide_all_slots;
      int i;
      for (i = 0; i < SPRITES; i++) begin
         cur_slot[i].pattern  = HIDDEN_PATTERN;
         prev_slot[i].pattern = HIDDEN_PATTERN;
         old_slot[i].pattern  = HIDDEN_PATTERN;
      end
   endtask

   task automatic reset_table;
      int i;
      for (i = 0; i < SPRITES; i++) begin
         cur_slot[i]  = '0;
         prev_slot[i] = '0;
         old_slot[i]  = '0;
      end
      hide_all_slots();
      y_offset_reg = Y_OFFSET_RESET;
      max_y_reg    = MAX_Y_RESET;
      frame_ops_q.delete();
   endtask

   task automatic push_frame_op(input rsp_op_type op, input slot_type s, input logic last);
      frame_op_type e;
      e.op   = op;
      e.slot = s;
      e.last = last;
      frame_ops_q.push_back(e);
   endtask

   // table edit or frame update for one request transfer
   task automatic apply_request(input cmd_type cmd, input logic [3:0] idx,
                                input logic [7:0] x, input logic [7:0] y,
                                input logic [7:0] pattern);
      slot_type blank;
      int       i;
      blank = '0;
      case (cmd)
         CMD_SHOW: begin
            if (idx < SPRITES) begin
               cur_slot[idx].x       = x;
               cur_slot[idx].y       = y + y_offset_reg;
               cur_slot[idx].pattern = pattern;
            end
         end
         CMD_HIDE: begin
            if (idx < SPRITES) cur_slot[idx].pattern = HIDDEN_PATTERN;
         end
         CMD_HIDE_ALL: begin
            hide_all_slots();
         end
         default: begin
            // erase pass, ageing only on-screen previous slots
            for (i = 0; i < SPRITES; i++) begin
               if (on_screen(old_slot[i])) push_frame_op(OP_ERASE, old_slot[i], 1'b0);
               if (on_screen(prev_slot[i])) old_slot[i] = prev_slot[i];
            end
            // draw pass, current always copied into previous
            for (i = 0; i < SPRITES; i++) begin
               if (on_screen(cur_slot[i])) push_frame_op(OP_DRAW, cur_slot[i], 1'b0);
               prev_slot[i] = cur_slot[i];
            end
            push_frame_op(OP_SWAP, blank, 1'b1);
         end
      endcase
   endtask

   task automatic check_result;
      frame_op_type want;
      if (frame_ops_q.size() == 0) begin
         report_mismatch($sformatf("unexpected result op %0d x %0d y %0d pattern %0d last %0d",
                                   rsp_op, rsp_out_x, rsp_out_y, rsp_out_pattern, rsp_last));
      end else begin
         want = frame_ops_q.pop_front();
         if (rsp_op !== want.op)
            report_mismatch($sformatf("op got %0d want %0d", rsp_op, want.op));
         if (rsp_out_x !== want.slot.x)
            report_mismatch($sformatf("out_x got %0d want %0d", rsp_out_x, want.slot.x));
         if (rsp_out_y !== want.slot.y)
            report_mismatch($sformatf("out_y got %0d want %0d", rsp_out_y, want.slot.y));
         if (rsp_out_pattern !== want.slot.pattern)
            report_mismatch($sformatf("out_pattern got %0d want %0d",
                                      rsp_out_pattern, want.slot.pattern));
         if (rsp_last !== want.last)
            report_mismatch($sformatf("last got %0d want %0d", rsp_last, want.last));
      end
   endtask

   // sample every transfer at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         reset_table();
      end else begin
         if (rsp_valid && !rsp_stall) check_result();
         if (psel && penable && pwrite && pready) begin
            if (paddr == Y_OFFSET_ADDR) y_offset_reg = pwdata[7:0];
            else if (paddr == MAX_Y_ADDR) max_y_reg = pwdata[7:0];
         end
         if (req_valid && !req_stall)
            apply_request(cmd_type'(req_cmd), req_index, req_x, req_y, req_pattern);
      end
      pending = frame_ops_q.size();
   end

endmodule

[tb/tb_sprite_erase_redraw_scheduler.sv]
// testbench top for the sprite erase/redraw scheduler: clock, reset, request and
// register stimulus, response stalls and the verdict
// depends on ser_pkg, sprite_erase_redraw_scheduler and ser_checker
module tb_sprite_erase_redraw_scheduler;
   timeunit 1ns;
   timeprecision 1ps;
   import ser_pkg::*;

   localparam int CLOCK_HALF    = 4;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 3 * SPRITE_COUNT_DEFAULT + 2 + 8;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 78;

   localparam logic [CSR_ADDR_W-1:0] Y_OFFSET_ADDR = CSR_ADDR_W'(4 * CSR_REG_Y_OFFSET);
   localparam logic [CSR_ADDR_W-1:0] MAX_Y_ADDR    = CSR_ADDR_W'(4 * CSR_REG_MAX_Y);

   logic                  clock           = 1'b0;
   logic                  reset           = 1'b1;
   logic                  req_valid       = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_cmd         = '0;
   logic [3:0]            req_index       = '0;
   logic [7:0]            req_x           = '0;
   logic [7:0]            req_y           = '0;
   logic [7:0]            req_pattern     = '0;
   logic                  rsp_valid;
   logic                  rsp_stall       = 1'b0;
   logic [1:0]            rsp_op;
   logic [7:0]            rsp_out_x;
   logic [7:0]            rsp_out_y;
   logic [7:0]            rsp_out_pattern;
   logic                  rsp_last;
   logic                  psel            = 1'b0;
   logic                  penable         = 1'b0;
   logic                  pwrite          = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr           = '0;
   logic [CSR_DATA_W-1:0] pwdata          = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int fail_count;
   int pending;
   int cycle_count = 0;
   bit no_idle     = 1'b0;
   bit rsp_took    = 1'b0;
   int stall_left  = 0;

   sprite_erase_redraw_scheduler DUT (.*);

   ser_checker CHECKER (.*);

   always #(CLOCK_HALF) clock = ~clock;

   // response side: random stall after each transfer, sometimes before the first one
   always @(posedge clock) rsp_took <= rsp_valid && !rsp_stall;

   always @(negedge clock) begin
      if (rsp_took || (!rsp_valid && stall_left == 0 && $urandom_range(0, 3) == 0))
         stall_left = no_idle ? 0 : $urandom_range(0, 7);
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // one request transfer after a random gap; valid stays high into a back-to-back item
   task automatic send_req(input cmd_type cmd, input logic [3:0] idx, input logic [7:0] x,
                           input logic [7:0] y, input logic [7:0] pattern);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_cmd     <= cmd;
      req_index   <= idx;
      req_x       <= x;
      req_y       <= y;
      req_pattern <= pattern;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // setup then access cycle; pready is sampled at the access edge
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [7:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // hold off until every owed result has come, then let the sequencer settle
   task automatic wait_idle;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic random_req;
      int         pick;
      logic [7:0] pattern;
      pick    = $urandom_range(0, 99);
      pattern = ($urandom_range(0, 9) == 0) ? HIDDEN_PATTERN : 8'($urandom);
      if (pick < 50)
         send_req(CMD_SHOW, 4'($urandom), 8'($urandom), 8'($urandom), pattern);
      else if (pick < 65)
         send_req(CMD_HIDE, 4'($urandom), 8'($urandom), 8'($urandom), pattern);
      else if (pick < 68)
         send_req(CMD_HIDE_ALL, 4'($urandom), 8'($urandom), 8'($urandom), pattern);
      else
         send_req(CMD_UPDATE, 4'($urandom), 8'($urandom), 8'($urandom), pattern);
      // occasional drain mid-stream and stretches without idling
      if ($urandom_range(0, 49) == 0) wait_idle();
      if ($urandom_range(0, 31) == 0) no_idle = !no_idle;
   endtask

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int         phase;
      int         n;
      logic [7:0] yoff;
      logic [7:0] ymax;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset register values: empty frame, edges of the fields, off-screen and hidden shows
      send_req(CMD_UPDATE, 4'd0, 8'd0, 8'd0, 8'd0);
      send_req(CMD_SHOW, 4'd0, 8'd0, 8'd0, 8'd0);
      send_req(CMD_SHOW, 4'd15, 8'd255, 8'd176, 8'd254);
      send_req(CMD_SHOW, 4'd7, 8'hAA, 8'd177, 8'h55);
      send_req(CMD_SHOW, 4'd3, 8'h55, 8'd170, HIDDEN_PATTERN);
      send_req(CMD_UPDATE, 4'd15, 8'hFF, 8'hFF, 8'hFF);
      // hidden previous slot: the oldest copy is erased again on each update until hide all
      send_req(CMD_HIDE, 4'd15, 8'd0, 8'd0, 8'd0);
      send_req(CMD_UPDATE, 4'd0, 8'd0, 8'd0, 8'd0);
      send_req(CMD_UPDATE, 4'd0, 8'd0, 8'd0, 8'd0);
      send_req(CMD_UPDATE, 4'd0, 8'd0, 8'd0, 8'd0);
      send_req(CMD_HIDE_ALL, 4'd0, 8'd0, 8'd0, 8'd0);
      send_req(CMD_UPDATE, 4'd0, 8'd0, 8'd0, 8'd0);

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       begin yoff = 8'd0;   ymax = 8'd255; end
            1:       begin yoff = 8'd255; ymax = 8'd0;   end
            2:       begin yoff = 8'd200; ymax = 8'd100; end
            3:       begin yoff = 8'd0;   ymax = 8'd176; end
            default: begin yoff = 8'($urandom); ymax = 8'($urandom); end
         endcase
         no_idle = (phase == 3);
         wait_idle();
         csr_write(Y_OFFSET_ADDR, yoff);
         csr_write(MAX_Y_ADDR, ymax);
         if (phase == 0) begin
            // bottom row still on screen
            send_req(CMD_SHOW, 4'd5, 8'd1, 8'd255, 8'd128);
            send_req(CMD_UPDATE, 4'd0, 8'd0, 8'd0, 8'd0);
         end else if (phase == 1) begin
            // offset wraps to row 0, the only row on screen
            send_req(CMD_SHOW, 4'd1, 8'd10, 8'd1, 8'd2);
            send_req(CMD_SHOW, 4'd2, 8'd20, 8'd2, 8'd3);
            send_req(CMD_UPDATE, 4'd0, 8'd0, 8'd0, 8'd0);
            send_req(CMD_UPDATE, 4'd0, 8'd0, 8'd0, 8'd0);
         end
         for (n = 0; n < PHASE_ITEMS; n++) random_req();
      end

      wait_idle();
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/ser_pkg.sv
rtl/core/ser_table.sv
rtl/core/ser_ctrl.sv
rtl/core/sprite_erase_redraw_scheduler.sv
tb/ser_checker.sv
tb/tb_sprite_erase_redraw_scheduler.sv
